@@ hw/rtl/vlmr_pkg.sv @@
// Shared constants, codes and controller/datapath interface types of the mailbox ring.
package vlmr_pkg;

    localparam int DEF_SLOTS          = 16;
    localparam int DEF_MAX_ITEM_BYTES = 255;

    localparam int PADDR_W   = 3;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;
    localparam int STATUS_W  = 3;

    localparam int REG_SLOT_COUNT = 0;
    localparam int REG_SLOT_BYTES = 1;

    localparam logic CMD_SEND = 1'b0;
    localparam logic CMD_RECV = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_LENGTH  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EVT_REFUSED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd4;

    localparam logic [8:0] SEND_COUNT_MAX = 9'd511;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic send;
        logic len_load;
        logic emit_empty;
        logic issue;
        logic emit_zero;
        logic emit_word;
    } vlmr_cmd_t;

    typedef struct packed {
        logic is_recv;
        logic is_last;
        logic ring_empty;
        logic len_zero;
        logic word_last;
        logic out_free;
    } vlmr_stat_t;

endpackage

@@ hw/rtl/vlmr_regs.sv @@
// APB configuration registers: slot count and slot size, with saturation on write.
module vlmr_regs #(
    parameter int SLOTS          = vlmr_pkg::DEF_SLOTS,
    parameter int MAX_ITEM_BYTES = vlmr_pkg::DEF_MAX_ITEM_BYTES,
    parameter int SCW            = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vlmr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [SCW-1:0]               slot_count,
    output logic [7:0]                   slot_bytes,
    output logic                         cfg_clear
);

    logic [SCW-1:0] slot_count_reg;
    logic [SCW-1:0] slot_count_next;
    logic [7:0]     slot_bytes_reg;
    logic [7:0]     slot_bytes_next;
    logic           wr_en;
    logic           sel_item;
    logic [4:0]     sc_in;
    logic [7:0]     is_in;
    logic [SCW-1:0] sc_sat;
    logic [7:0]     is_sat;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;
    assign sel_item = (paddr[2] == 1'(vlmr_pkg::REG_SLOT_BYTES));
    assign sc_in    = pwdata[4:0];
    assign is_in    = pwdata[7:0];

    always_comb
    begin
        priority if (sc_in == 5'd0)
        begin
            sc_sat = SCW'(1);
        end
        else if (SCW'(sc_in) > SCW'(SLOTS))
        begin
            sc_sat = SCW'(SLOTS);
        end
        else
        begin
            sc_sat = SCW'(sc_in);
        end

        priority if (is_in == 8'd0)
        begin
            is_sat = 8'd1;
        end
        else if (is_in > 8'(MAX_ITEM_BYTES))
        begin
            is_sat = 8'(MAX_ITEM_BYTES);
        end
        else
        begin
            is_sat = is_in;
        end

        slot_count_next = slot_count_reg;
        slot_bytes_next = slot_bytes_reg;
        if (wr_en)
        begin
            if (sel_item)
            begin
                slot_bytes_next = is_sat;
            end
            else
            begin
                slot_count_next = sc_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= SCW'(SLOTS);
            slot_bytes_reg <= 8'(MAX_ITEM_BYTES);
        end
        else
        begin
            slot_count_reg <= slot_count_next;
            slot_bytes_reg <= slot_bytes_next;
        end
    end

    assign prdata     = sel_item ? 32'(slot_bytes_reg) : 32'(slot_count_reg);
    assign slot_count = slot_count_reg;
    assign slot_bytes = slot_bytes_reg;
    assign cfg_clear  = wr_en;

endmodule

@@ hw/rtl/vlmr_ctrl.sv @@
// Controller state machine that sequences send, length lookup and word readout.
module vlmr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  vlmr_pkg::vlmr_stat_t stat,
    output vlmr_pkg::vlmr_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_SEND   = 3'd2;
    localparam logic [2:0] S_RLEN   = 3'd3;
    localparam logic [2:0] S_RISSUE = 3'd4;
    localparam logic [2:0] S_RDATA  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = stat.is_recv ? S_RLEN : S_SEND;
            end
            S_SEND:
            begin
                if (!stat.is_last || stat.out_free)
                begin
                    cmd.send   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RLEN:
            begin
                if (stat.ring_empty)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit_empty = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    cmd.len_load = 1'b1;
                    state_next   = S_RISSUE;
                end
            end
            S_RISSUE:
            begin
                if (stat.len_zero)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit_zero = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.issue  = 1'b1;
                    state_next = S_RDATA;
                end
            end
            S_RDATA:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_word = 1'b1;
                    state_next    = stat.word_last ? S_IDLE : S_RISSUE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/vlmr_dp.sv @@
// Datapath: ring pointers, four byte-lane message stores, length table and output register.
module vlmr_dp #(
    parameter int SLOTS          = vlmr_pkg::DEF_SLOTS,
    parameter int MAX_ITEM_BYTES = vlmr_pkg::DEF_MAX_ITEM_BYTES,
    parameter int SCW            = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [SCW-1:0]                slot_count,
    input  logic [7:0]                    slot_bytes,
    input  logic                          cfg_clear,
    input  logic                          in_cmd,
    input  logic [31:0]                   in_data,
    input  logic [2:0]                    in_bytes,
    input  logic                          in_last,
    input  logic                          in_evt,
    input  vlmr_pkg::vlmr_cmd_t           cmd,
    output vlmr_pkg::vlmr_stat_t          stat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [vlmr_pkg::STATUS_W-1:0] out_status,
    output logic [31:0]                   out_word,
    output logic [2:0]                    out_bytes,
    output logic [7:0]                    out_len,
    output logic                          out_last
);

    localparam int RW          = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TW          = SCW + 1;
    localparam int STORE_BYTES = SLOTS * MAX_ITEM_BYTES;
    localparam int DEPTH       = (STORE_BYTES + 3) / 4;
    localparam int ROWW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AW          = $clog2(STORE_BYTES + 512);

    // Captured input beat.
    logic           in_cmd_reg;
    logic [31:0]    in_data_reg;
    logic [2:0]     in_bytes_reg;
    logic           in_last_reg;
    logic           in_evt_reg;

    // Ring state.
    logic [RW-1:0]  read_slot_reg;
    logic [RW-1:0]  read_slot_next;
    logic [SCW-1:0] filled_reg;
    logic [SCW-1:0] filled_next;
    logic [8:0]     sent_reg;
    logic [8:0]     sent_next;
    logic           lost_reg;
    logic           lost_next;

    // Per-item working registers.
    logic [RW-1:0]  slot_reg;
    logic [AW-1:0]  base_reg;
    logic [7:0]     len_raw_reg;
    logic [7:0]     len_reg;
    logic [7:0]     pos_reg;
    logic [2:0]     chunk_reg;
    logic [1:0]     align_reg;
    logic           word_last_reg;

    logic           out_valid_reg;
    logic [vlmr_pkg::STATUS_W-1:0] out_status_reg;
    logic [31:0]    out_word_reg;
    logic [2:0]     out_bytes_reg;
    logic [7:0]     out_len_reg;
    logic           out_last_reg;

    logic [7:0]     len_mem [SLOTS];

    logic [TW-1:0]  tail_sum;
    logic [TW-1:0]  tail_full;
    logic [RW-1:0]  tail;
    logic [RW-1:0]  slot_sel;
    logic           ring_full;
    logic [2:0]     n_bytes;
    logic [3:0]     byte_act;
    logic [3:0]     byte_wr;
    logic [9:0]     off [4];
    logic [9:0]     sent_sum;
    logic [8:0]     sent_new;
    logic           lost_new;
    logic           len_bad;
    logic [vlmr_pkg::STATUS_W-1:0] send_status;
    logic           commit;
    logic           advance;
    logic [TW-1:0]  rs_inc;

    logic [AW-1:0]  addr0;
    logic [AW-3:0]  row0;
    logic [1:0]     lane_sel [4];
    logic [ROWW-1:0] row [4];
    logic [3:0]     wr_en;
    logic [7:0]     wr_data [4];
    logic [3:0][7:0] rd_byte;

    logic [7:0]     rem;
    logic [2:0]     chunk;
    logic [1:0]     bank_sel [4];
    logic [31:0]    word_asm;

    logic           out_load;
    logic [vlmr_pkg::STATUS_W-1:0] status_d;
    logic [31:0]    word_d;
    logic [2:0]     bytes_d;
    logic [7:0]     len_d;

    // Tail slot, byte enables and send verdict.
    always_comb
    begin
        tail_sum  = TW'(read_slot_reg) + TW'(filled_reg);
        tail_full = (tail_sum >= TW'(slot_count)) ? tail_sum - TW'(slot_count) : tail_sum;
        tail      = RW'(tail_full);
        slot_sel  = (in_cmd_reg == vlmr_pkg::CMD_RECV) ? read_slot_reg : tail;
        ring_full = (filled_reg >= slot_count);
        n_bytes   = (in_bytes_reg > 3'd4) ? 3'd4 : in_bytes_reg;

        for (int i = 0; i < 4; i++)
        begin
            off[i]      = 10'(sent_reg) + 10'(i);
            byte_act[i] = (3'(i) < n_bytes) && (off[i] < 10'(slot_bytes));
        end
        byte_wr  = byte_act & {4{!ring_full}};
        lost_new = lost_reg || ((|byte_act) && ring_full);

        sent_sum = 10'(sent_reg) + 10'(n_bytes);
        sent_new = (sent_sum > 10'(vlmr_pkg::SEND_COUNT_MAX)) ?
                   vlmr_pkg::SEND_COUNT_MAX : sent_sum[8:0];
        len_bad  = (sent_new == 9'd0) || (sent_new > 9'(slot_bytes));

        priority if (len_bad)
        begin
            send_status = vlmr_pkg::ST_BAD_LENGTH;
        end
        else if (ring_full || lost_new)
        begin
            send_status = vlmr_pkg::ST_FULL;
        end
        else if (!in_evt_reg)
        begin
            send_status = vlmr_pkg::ST_EVT_REFUSED;
        end
        else
        begin
            send_status = vlmr_pkg::ST_OK;
        end

        commit  = cmd.send && in_last_reg && (send_status == vlmr_pkg::ST_OK);
        advance = cmd.emit_zero || (cmd.emit_word && word_last_reg);
        rs_inc  = TW'(read_slot_reg) + TW'(1);
    end

    // Ring state update.
    always_comb
    begin
        read_slot_next = read_slot_reg;
        filled_next    = filled_reg;
        sent_next      = sent_reg;
        lost_next      = lost_reg;
        if (cfg_clear)
        begin
            read_slot_next = '0;
            filled_next    = '0;
            sent_next      = '0;
            lost_next      = 1'b0;
        end
        else
        begin
            if (cmd.send)
            begin
                if (in_last_reg)
                begin
                    sent_next = '0;
                    lost_next = 1'b0;
                    if (commit)
                    begin
                        filled_next = filled_reg + SCW'(1);
                    end
                end
                else
                begin
                    sent_next = sent_new;
                    lost_next = lost_new;
                end
            end
            if (advance)
            begin
                read_slot_next = (rs_inc >= TW'(slot_count)) ? '0 : RW'(rs_inc);
                filled_next    = filled_reg - SCW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_slot_reg <= '0;
            filled_reg    <= '0;
            sent_reg      <= '0;
            lost_reg      <= 1'b0;
        end
        else
        begin
            read_slot_reg <= read_slot_next;
            filled_reg    <= filled_next;
            sent_reg      <= sent_next;
            lost_reg      <= lost_next;
        end
    end

    // Byte-lane addressing shared by writes and reads.
    always_comb
    begin
        addr0 = base_reg + (cmd.send ? AW'(sent_reg) : AW'(pos_reg));
        row0  = addr0[AW-1:2];
        for (int b = 0; b < 4; b++)
        begin
            lane_sel[b] = 2'(b) - addr0[1:0];
            row[b]      = ROWW'(row0 + (AW-2)'((2'(b) < addr0[1:0]) ? 1 : 0));
            wr_en[b]    = cmd.send && byte_wr[lane_sel[b]];
            wr_data[b]  = in_data_reg[8*lane_sel[b] +: 8];
        end
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_lane
        logic [7:0] store_mem [DEPTH];
        logic [7:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (wr_en[b])
            begin
                store_mem[row[b]] <= wr_data[b];
            end
            if (cmd.issue)
            begin
                rd_reg <= store_mem[row[b]];
            end
        end

        assign rd_byte[b] = rd_reg;
    end

    // Word readout.
    always_comb
    begin
        rem   = len_reg - pos_reg;
        chunk = (rem > 8'd4) ? 3'd4 : rem[2:0];
        for (int j = 0; j < 4; j++)
        begin
            bank_sel[j]       = 2'(j) + align_reg;
            word_asm[8*j +: 8] = (3'(j) < chunk_reg) ? rd_byte[bank_sel[j]] : 8'd0;
        end
    end

    // Output payload selection.
    always_comb
    begin
        out_load = (cmd.send && in_last_reg) || cmd.emit_empty || cmd.emit_zero ||
                   cmd.emit_word;
        status_d = vlmr_pkg::ST_OK;
        word_d   = '0;
        bytes_d  = '0;
        len_d    = '0;
        priority if (cmd.send)
        begin
            status_d = send_status;
        end
        else if (cmd.emit_empty)
        begin
            status_d = vlmr_pkg::ST_EMPTY;
        end
        else if (cmd.emit_word)
        begin
            word_d  = word_asm;
            bytes_d = chunk_reg;
            len_d   = len_reg;
        end
        else
        begin
            status_d = vlmr_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_cmd_reg   <= in_cmd;
            in_data_reg  <= in_data;
            in_bytes_reg <= in_bytes;
            in_last_reg  <= in_last;
            in_evt_reg   <= in_evt;
        end
        if (cmd.prep)
        begin
            slot_reg    <= slot_sel;
            base_reg    <= AW'(slot_sel) * AW'(slot_bytes);
            len_raw_reg <= len_mem[read_slot_reg];
        end
        if (commit)
        begin
            len_mem[slot_reg] <= sent_new[7:0];
        end
        if (cmd.len_load)
        begin
            len_reg <= (len_raw_reg > slot_bytes) ? slot_bytes : len_raw_reg;
            pos_reg <= '0;
        end
        if (cmd.issue)
        begin
            align_reg     <= addr0[1:0];
            chunk_reg     <= chunk;
            pos_reg       <= pos_reg + 8'(chunk);
            word_last_reg <= ((pos_reg + 8'(chunk)) == len_reg);
        end
        if (out_load)
        begin
            out_status_reg <= status_d;
            out_word_reg   <= word_d;
            out_bytes_reg  <= bytes_d;
            out_len_reg    <= len_d;
            out_last_reg   <= (cmd.emit_word) ? word_last_reg : 1'b1;
        end
    end

    assign stat.is_recv    = (in_cmd_reg == vlmr_pkg::CMD_RECV);
    assign stat.is_last    = in_last_reg;
    assign stat.ring_empty = (filled_reg == '0);
    assign stat.len_zero   = (len_reg == 8'd0);
    assign stat.word_last  = word_last_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_word   = out_word_reg;
    assign out_bytes  = out_bytes_reg;
    assign out_len    = out_len_reg;
    assign out_last   = out_last_reg;

endmodule

@@ hw/rtl/variable_length_mailbox_ring_unit.sv @@
// Top level of the variable-length mailbox ring: stream ports, APB registers and core wiring.
// The ring holds slot_count slots, each as large as the slot size register, in four byte-lane
// stores. A send word passes capture, slot address and store write after acceptance,
// and a send result leaves on the word marked tlast. A receive first looks up the head slot
// and its length, then produces each result beat by a lane read and a beat assembly;
// these steps come from the registered reads of the length table and the byte-lane stores.
// A new beat is accepted once the previous item is done, even while its last result still
// waits in the output register. Writing either register empties the ring. There is no
// clearing pass after reset.
module variable_length_mailbox_ring_unit #(
    parameter int SLOTS          = vlmr_pkg::DEF_SLOTS,
    parameter int MAX_ITEM_BYTES = vlmr_pkg::DEF_MAX_ITEM_BYTES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0: data_word[31:0], byte_count[34:32], event_accepted[35], zero fill.
    input  logic [vlmr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // Fields from bit 0: cmd[0].
    input  logic                           s_axis_tuser,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Fields from bit 0: out_word[31:0], out_bytes[34:32], message_length[42:35], zero fill.
    output logic [vlmr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: status[2:0].
    output logic [vlmr_pkg::STATUS_W-1:0]  m_axis_tuser,
    output logic                           m_axis_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vlmr_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int SCW = ($clog2(SLOTS + 1) > 5) ? $clog2(SLOTS + 1) : 5;

    logic [SCW-1:0]       slot_count;
    logic [7:0]           slot_bytes;
    logic                 cfg_clear;
    vlmr_pkg::vlmr_cmd_t  cmd;
    vlmr_pkg::vlmr_stat_t stat;
    logic [31:0]          out_word;
    logic [2:0]           out_bytes;
    logic [7:0]           out_len;

    vlmr_regs #(
        .SLOTS          (SLOTS),
        .MAX_ITEM_BYTES (MAX_ITEM_BYTES),
        .SCW            (SCW)
    ) u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .slot_count (slot_count),
        .slot_bytes (slot_bytes),
        .cfg_clear  (cfg_clear)
    );

    vlmr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vlmr_dp #(
        .SLOTS          (SLOTS),
        .MAX_ITEM_BYTES (MAX_ITEM_BYTES),
        .SCW            (SCW)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot_count (slot_count),
        .slot_bytes (slot_bytes),
        .cfg_clear  (cfg_clear),
        .in_cmd     (s_axis_tuser),
        .in_data    (s_axis_tdata[31:0]),
        .in_bytes   (s_axis_tdata[34:32]),
        .in_last    (s_axis_tlast),
        .in_evt     (s_axis_tdata[35]),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_word   (out_word),
        .out_bytes  (out_bytes),
        .out_len    (out_len),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, out_len, out_bytes, out_word};

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the variable-length mailbox ring: directed and random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES = 150;

    typedef struct packed {
        logic        cmd;
        logic [31:0] word;
        logic [2:0]  nb;
        logic        last;
        logic        evt;
    } ring_beat_t;

    typedef struct packed {
        logic [vlmr_pkg::STATUS_W-1:0] status;
        logic [31:0]                   word;
        logic [2:0]                    nbytes;
        logic [7:0]                    mlen;
        logic                          last;
    } ring_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [vlmr_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                           s_axis_tuser = 1'b0;
    logic                           s_axis_tlast = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [vlmr_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [vlmr_pkg::STATUS_W-1:0]  m_axis_tuser;
    logic                           m_axis_tlast;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [vlmr_pkg::PADDR_W-1:0]   paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    // Mirror of the ring contents and settings.
    logic [7:0]   ring_bytes [0:vlmr_pkg::DEF_SLOTS*vlmr_pkg::DEF_MAX_ITEM_BYTES-1];
    logic [7:0]   slot_len [0:vlmr_pkg::DEF_SLOTS-1];
    int           head_slot = 0;
    int           used_slots = 0;
    int           open_len = 0;
    bit           open_lost = 1'b0;
    int           cfg_slots = vlmr_pkg::DEF_SLOTS;
    int           cfg_size = vlmr_pkg::DEF_MAX_ITEM_BYTES;

    ring_result_t due_results [$];
    int           mismatches = 0;
    int           beats_sent = 0;
    int           cycle_count = 0;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           hold_off_left = 0;

    variable_length_mailbox_ring_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // The receiver honors a long hold-off first, then stalls at random.
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            m_axis_tready = 1'b0;
            hold_off_left--;
        end
        else
        begin
            m_axis_tready = ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        ring_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t unexpected beat: status %0d word %h", $time, m_axis_tuser,
                         m_axis_tdata[31:0]);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                if (m_axis_tuser !== want.status)
                begin
                    $display("%0t status: expected %0d, actual %0d", $time, want.status,
                             m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[31:0] !== want.word)
                begin
                    $display("%0t out_word: expected %h, actual %h", $time, want.word,
                             m_axis_tdata[31:0]);
                    mismatches++;
                end
                if (m_axis_tdata[34:32] !== want.nbytes)
                begin
                    $display("%0t out_bytes: expected %0d, actual %0d", $time, want.nbytes,
                             m_axis_tdata[34:32]);
                    mismatches++;
                end
                if (m_axis_tdata[42:35] !== want.mlen)
                begin
                    $display("%0t message_length: expected %0d, actual %0d", $time, want.mlen,
                             m_axis_tdata[42:35]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t out_last: expected %0d, actual %0d", $time, want.last,
                             m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    function automatic ring_beat_t beat_of(logic cmd, logic [31:0] word, logic [2:0] nb,
                                           logic last, logic evt);
        ring_beat_t b;
        b.cmd = cmd;
        b.word = word;
        b.nb = nb;
        b.last = last;
        b.evt = evt;
        return b;
    endfunction

    task automatic ring_clear();
        head_slot = 0;
        used_slots = 0;
        open_len = 0;
        open_lost = 1'b0;
    endtask

    task automatic ring_configure(input int reg_index, input logic [31:0] value);
        int v;
        if (reg_index == vlmr_pkg::REG_SLOT_COUNT)
        begin
            v = int'(value & 32'h1F);
            if (v < 1) v = 1;
            if (v > vlmr_pkg::DEF_SLOTS) v = vlmr_pkg::DEF_SLOTS;
            cfg_slots = v;
            ring_clear();
        end
        else if (reg_index == vlmr_pkg::REG_SLOT_BYTES)
        begin
            v = int'(value & 32'hFF);
            if (v < 1) v = 1;
            if (v > vlmr_pkg::DEF_MAX_ITEM_BYTES) v = vlmr_pkg::DEF_MAX_ITEM_BYTES;
            cfg_size = v;
            ring_clear();
        end
    endtask

    // Works out the result beats that one accepted beat causes.
    task automatic ring_apply(input ring_beat_t b);
        int tail;
        int cnt;
        int len;
        int pos;
        int c;
        int base;
        logic [31:0] w;
        ring_result_t r;
        r = '0;
        r.last = 1'b1;
        if (b.cmd == vlmr_pkg::CMD_SEND)
        begin
            tail = (head_slot + used_slots) % cfg_slots;
            cnt = (b.nb > 3'd4) ? 4 : int'(b.nb);
            for (int i = 0; i < cnt; i++)
            begin
                if (open_len < cfg_size)
                begin
                    if (used_slots >= cfg_slots)
                        open_lost = 1'b1;
                    else
                        ring_bytes[tail * cfg_size + open_len] = b.word[8*i +: 8];
                end
                if (open_len < 511) open_len++;
            end
            if (b.last)
            begin
                if (open_len == 0 || open_len > cfg_size)
                    r.status = vlmr_pkg::ST_BAD_LENGTH;
                else if (used_slots >= cfg_slots || open_lost)
                    r.status = vlmr_pkg::ST_FULL;
                else if (!b.evt)
                    r.status = vlmr_pkg::ST_EVT_REFUSED;
                else
                begin
                    slot_len[tail] = 8'(open_len);
                    used_slots++;
                    r.status = vlmr_pkg::ST_OK;
                end
                open_len = 0;
                open_lost = 1'b0;
                due_results.push_back(r);
            end
        end
        else if (used_slots == 0)
        begin
            r.status = vlmr_pkg::ST_EMPTY;
            due_results.push_back(r);
        end
        else
        begin
            len = int'(slot_len[head_slot]);
            if (len > cfg_size) len = cfg_size;
            base = head_slot * cfg_size;
            pos = 0;
            if (len == 0)
                due_results.push_back(r);
            while (pos < len)
            begin
                c = (len - pos > 4) ? 4 : len - pos;
                w = '0;
                for (int j = 0; j < c; j++)
                    w[8*j +: 8] = ring_bytes[base + pos + j];
                pos += c;
                r.status = vlmr_pkg::ST_OK;
                r.word = w;
                r.nbytes = 3'(c);
                r.mlen = 8'(len);
                r.last = (pos >= len);
                due_results.push_back(r);
            end
            head_slot = (head_slot + 1 >= cfg_slots) ? 0 : head_slot + 1;
            used_slots--;
        end
    endtask

    task automatic push_beat(input ring_beat_t b);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {4'b0000, b.evt, b.nb, b.word};
        s_axis_tuser = b.cmd;
        s_axis_tlast = b.last;
        do @(posedge clk); while (!s_axis_tready);
        ring_apply(b);
        beats_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_write(input int reg_index, input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = vlmr_pkg::PADDR_W'(reg_index * 4);
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        ring_configure(reg_index, value);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_ring_config(input logic [31:0] slots_val, input logic [31:0] size_val);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_write(vlmr_pkg::REG_SLOT_COUNT, slots_val);
        apb_write(vlmr_pkg::REG_SLOT_BYTES, size_val);
    endtask

    task automatic recv_head();
        push_beat(beat_of(vlmr_pkg::CMD_RECV, $urandom, 3'($urandom_range(7)), 1'($urandom),
                          1'($urandom)));
    endtask

    // Sends a message of about len bytes; odd byte counts show up now and then.
    task automatic send_message(input int len, input logic evt);
        int sent;
        int raw;
        int eff;
        ring_beat_t b;
        sent = 0;
        while (sent < len)
        begin
            raw = ($urandom_range(99) < 8) ? $urandom_range(7) : $urandom_range(1, 4);
            eff = (raw > 4) ? 4 : raw;
            b = beat_of(vlmr_pkg::CMD_SEND, $urandom, 3'(raw), sent + eff >= len,
                        1'($urandom));
            if (b.last) b.evt = evt;
            push_beat(b);
            sent += eff;
        end
    endtask

    task automatic test_directed_basic();
        recv_head();
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0));
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'h0000_00A5, 3'd1, 1'b1, 1'b1));
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'h8000_0001, 3'd7, 1'b1, 1'b1));
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'hDEAD_BEEF, 3'd0, 1'b1, 1'b1));
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'h1234_5678, 3'd2, 1'b1, 1'b0));
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'h0102_0304, 3'd5, 1'b0, 1'b1));
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'hF0E0_D0C0, 3'd6, 1'b0, 1'b0));
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'h5555_5555, 3'd0, 1'b0, 1'b1));
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'h00AA_BBCC, 3'd3, 1'b1, 1'b1));
        recv_head();
        recv_head();
        recv_head();
        recv_head();
    endtask

    // One slot of four bytes: full ring, bytes lost to a full ring, overlong messages.
    task automatic test_full_ring();
        set_ring_config(32'd1, 32'd4);
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'hCAFE_F00D, 3'd4, 1'b1, 1'b1));
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'h0000_0011, 3'd1, 1'b1, 1'b1));
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'hFFFF_FFFF, 3'd4, 1'b0, 1'b1));
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'h0000_3344, 3'd2, 1'b1, 1'b0));
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'h0000_7766, 3'd2, 1'b0, 1'b1));
        recv_head();
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'h0000_0099, 3'd1, 1'b1, 1'b1));
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'h1122_3344, 3'd4, 1'b0, 1'b1));
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'h0000_0055, 3'd1, 1'b1, 1'b1));
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'h0000_0000, 3'd4, 1'b1, 1'b1));
        recv_head();
    endtask

    task automatic test_register_limits();
        set_ring_config(32'd0, 32'd0);
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'h0000_007E, 3'd1, 1'b1, 1'b1));
        push_beat(beat_of(vlmr_pkg::CMD_SEND, 32'h0000_7E7E, 3'd2, 1'b1, 1'b1));
        recv_head();
        set_ring_config(32'hFFFF_FFE3, 32'h0000_01FF);
        set_ring_config(32'd31, 32'd255);
    endtask

    // The length counter must stop at its ceiling instead of wrapping to a legal value.
    task automatic test_length_ceiling();
        for (int i = 0; i < 130; i++)
            push_beat(beat_of(vlmr_pkg::CMD_SEND, $urandom, 3'd4, 1'b0, 1'b0));
        push_beat(beat_of(vlmr_pkg::CMD_SEND, $urandom, 3'd1, 1'b1, 1'b1));
        send_message($urandom_range(1, 8), 1'b1);
        recv_head();
    endtask

    task automatic test_backpressure();
        idle_pct = 0;
        stall_pct = 0;
        hold_off_left = 250;
        for (int i = 0; i < 6; i++)
        begin
            send_message(16, 1'b1);
            if (i % 2 == 1) recv_head();
        end
        wait_drained();
    endtask

    task automatic run_traffic(input int beats, input int idle, input int stall);
        int stop_at;
        int r;
        int len;
        int top;
        idle_pct = idle;
        stall_pct = stall;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 55)
            begin
                top = (cfg_size < 12) ? cfg_size : 12;
                r = $urandom_range(99);
                if (r < 65)
                    len = $urandom_range(1, top);
                else if (r < 85)
                    len = $urandom_range(1, cfg_size);
                else
                    len = $urandom_range(cfg_size, cfg_size + 3);
                send_message(len, $urandom_range(99) < 88);
            end
            else if (r < 90)
                recv_head();
            else
                push_beat(beat_of(vlmr_pkg::CMD_SEND, $urandom, 3'($urandom_range(7)),
                                  1'($urandom), 1'($urandom)));
        end
    endtask

    task automatic test_random_traffic();
        set_ring_config(32'd16, 32'd255);
        run_traffic(60, 0, 0);
        set_ring_config(32'd1, 32'd1);
        run_traffic(45, 67, 0);
        set_ring_config($urandom_range(2, 15), $urandom_range(2, 40));
        run_traffic(55, 0, 67);
        set_ring_config($urandom, $urandom);
        run_traffic(30, 11, 11);
        set_ring_config($urandom_range(1, 4), $urandom_range(1, 8));
        run_traffic(30, 11, 11);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_basic();
        test_full_ring();
        test_register_limits();
        test_length_ceiling();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && due_results.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
